/* design/gtp_pkg.sv */
// Shared types and constants for the GTP header validator.
// No dependencies; used by every other design file.
package gtp_pkg;

    // Verdict status codes
    localparam logic [2:0] ST_ACCEPTED   = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_NOT_PDU    = 3'd2;
    localparam logic [2:0] ST_GTP_PRIME  = 3'd3;
    localparam logic [2:0] ST_BAD_VER    = 3'd4;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd5;

    // Inner protocol codes
    localparam logic [1:0] NP_UNKNOWN = 2'd0;
    localparam logic [1:0] NP_IPV4    = 2'd1;
    localparam logic [1:0] NP_IPV6    = 2'd2;

    // Header field values and masks
    localparam logic [7:0] TYPE_GPDU     = 8'd255;
    localparam logic [7:0] FLAG_PT_MASK  = 8'h10;
    localparam logic [7:0] FLAG_OPT_MASK = 8'h07;
    localparam logic [3:0] INNER_IPV4    = 4'h4;
    localparam logic [3:0] INNER_IPV6    = 4'h6;

    // Fixed header sizes in bytes
    localparam int HDR_LEN_V0     = 20;
    localparam int HDR_LEN_V1     = 8;
    localparam int HDR_LEN_V1_OPT = 12;
    localparam int MIN_PKT_LEN    = 8;

    // Configuration register map
    localparam int         APB_ADDR_BITS = 3;
    localparam logic [0:0] REG_BYPASS    = 1'b0;

    // Field widths
    localparam int HLEN_BITS = 17;

    // One verdict item
    typedef struct packed {
        logic [2:0]           status;
        logic [HLEN_BITS-1:0] header_length;
        logic [1:0]           next_protocol;
        logic                 multiple_encap;
        logic                 bypass_request;
    } verdict_t;

endpackage

/* design/gtp_if.sv */
// Valid/ready channel interfaces for packet bytes and verdicts.
// Depends on gtp_pkg for field widths.
interface gtp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       outer_gtp_seen;

    modport source (output valid, output data_byte, output last_byte,
                    output outer_gtp_seen, input ready);
    modport sink   (input valid, input data_byte, input last_byte,
                    input outer_gtp_seen, output ready);
endinterface

interface gtp_verdict_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    status;
    logic [gtp_pkg::HLEN_BITS-1:0] header_length;
    logic [1:0]                    next_protocol;
    logic                          multiple_encap;
    logic                          bypass_request;

    modport source (output valid, output status, output header_length,
                    output next_protocol, output multiple_encap,
                    output bypass_request, input ready);
    modport sink   (input valid, input status, input header_length,
                    input next_protocol, input multiple_encap,
                    input bypass_request, output ready);
endinterface

/* design/gtp_header_validator.sv */
// GTP header validator: one packet byte per item, one verdict per packet.
// Throughput: one byte per cycle; a last byte waits on a full result register.
// A verdict is formed from the last byte in the input register, then held
// in the result register until the verdict channel takes it.
// Reset (rst_n low, asynchronous): channels empty, packet state and
// bypass enable cleared.
module gtp_header_validator
#(
    parameter int COUNT_BITS = 17
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gtp_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    gtp_byte_if.sink                          pkt,
    gtp_verdict_if.source                     verdict
);

    logic              bypass_enable;
    logic              res_load;
    logic              res_can_take;
    gtp_pkg::verdict_t res;

    gtp_cfg u_cfg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .bypass_enable (bypass_enable)
    );

    gtp_parse #(.COUNT_BITS(COUNT_BITS)) u_parse
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pkt           (pkt),
        .bypass_enable (bypass_enable),
        .res_can_take  (res_can_take),
        .res_load      (res_load),
        .res           (res)
    );

    gtp_result u_result
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_load     (res_load),
        .res          (res),
        .res_can_take (res_can_take),
        .verdict      (verdict)
    );

endmodule

/* design/gtp_cfg.sv */
// APB-style configuration register block (bypass enable).
// Depends on gtp_pkg for the register map.
module gtp_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gtp_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic                              bypass_enable
);

    logic bypass_enable_reg;
    logic bypass_enable_next;
    logic sel_bypass;

    // Register index is the word address
    assign sel_bypass = (paddr[gtp_pkg::APB_ADDR_BITS-1:2] == gtp_pkg::REG_BYPASS);
    assign pready     = 1'b1;

    always_comb
    begin
        bypass_enable_next = bypass_enable_reg;
        if (psel && penable && pwrite && pready && sel_bypass)
        begin
            bypass_enable_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_enable_reg <= 1'b0;
        end
        else
        begin
            bypass_enable_reg <= bypass_enable_next;
        end
    end

    // Read-back
    assign prdata        = sel_bypass ? {31'd0, bypass_enable_reg} : 32'd0;
    assign bypass_enable = bypass_enable_reg;

endmodule

/* design/gtp_parse.sv */
// Input register, per-packet header state and verdict logic.
// Depends on gtp_pkg and gtp_byte_if.
module gtp_parse
#(
    parameter int COUNT_BITS = 17
)
(
    input  logic              clk,
    input  logic              rst_n,
    gtp_byte_if.sink          pkt,
    input  logic              bypass_enable,
    input  logic              res_can_take,
    output logic              res_load,
    output gtp_pkg::verdict_t res
);

    localparam int CMPW = (COUNT_BITS > 17) ? COUNT_BITS : 17;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // Input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       s1_outer_reg;

    // Per-packet state
    logic [COUNT_BITS-1:0] byte_count_reg,   byte_count_next;
    logic [7:0]            flag_byte_reg,    flag_byte_next;
    logic [7:0]            type_byte_reg,    type_byte_next;
    logic [15:0]           length_field_reg, length_field_next;
    logic [COUNT_BITS-1:0] header_end_reg,   header_end_next;
    logic                  chain_active_reg, chain_active_next;
    logic                  chain_error_reg,  chain_error_next;
    logic [3:0]            inner_nib_reg,    inner_nib_next;
    logic                  outer_flag_reg,   outer_flag_next;

    logic                  go;
    logic                  advance;
    logic                  pkt_accept;
    logic [2:0]            ver_first;
    logic [COUNT_BITS:0]   i_plus1;
    logic [COUNT_BITS:0]   ext_sum;
    logic [2:0]            ver;
    logic [CMPW-1:0]       total_w;
    logic [CMPW-1:0]       len_v0;
    logic [CMPW-1:0]       len_v1;
    logic [2:0]            status;

    // Handshake: stall only a last byte whose verdict cannot be stored
    assign go         = !s1_last_reg || res_can_take;
    assign advance    = s1_valid_reg && go;
    assign pkt.ready  = !s1_valid_reg || go;
    assign pkt_accept = pkt.valid && pkt.ready;
    assign res_load   = advance && s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pkt_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_accept)
        begin
            s1_byte_reg  <= pkt.data_byte;
            s1_last_reg  <= pkt.last_byte;
            s1_outer_reg <= pkt.outer_gtp_seen;
        end
    end

    assign ver_first = s1_byte_reg[7:5];
    assign i_plus1   = {1'b0, byte_count_reg} + {{COUNT_BITS{1'b0}}, 1'b1};
    assign ext_sum   = {1'b0, header_end_reg}
                     + (COUNT_BITS+1)'({s1_byte_reg, 2'b00});

    // Header field capture and extension chain walk
    always_comb
    begin
        flag_byte_next    = flag_byte_reg;
        type_byte_next    = type_byte_reg;
        length_field_next = length_field_reg;
        header_end_next   = header_end_reg;
        chain_active_next = chain_active_reg;
        chain_error_next  = chain_error_reg;
        inner_nib_next    = inner_nib_reg;
        outer_flag_next   = outer_flag_reg;

        if (byte_count_reg == '0)
        begin
            flag_byte_next   = s1_byte_reg;
            outer_flag_next  = s1_outer_reg;
            chain_error_next = 1'b0;
            inner_nib_next   = 4'd0;
            if (ver_first == 3'd1 && (s1_byte_reg & gtp_pkg::FLAG_OPT_MASK) != 8'd0)
            begin
                chain_active_next = 1'b1;
                header_end_next   = COUNT_BITS'(gtp_pkg::HDR_LEN_V1_OPT);
            end
            else
            begin
                chain_active_next = 1'b0;
                header_end_next   = (ver_first == 3'd0) ? COUNT_BITS'(gtp_pkg::HDR_LEN_V0)
                                                        : COUNT_BITS'(gtp_pkg::HDR_LEN_V1);
            end
        end
        else
        begin
            if (byte_count_reg == COUNT_BITS'(1))
            begin
                type_byte_next = s1_byte_reg;
            end
            else if (byte_count_reg == COUNT_BITS'(2))
            begin
                length_field_next = {s1_byte_reg, 8'd0};
            end
            else if (byte_count_reg == COUNT_BITS'(3))
            begin
                length_field_next = {length_field_reg[15:8], s1_byte_reg};
            end

            if (chain_active_reg)
            begin
                // next-type byte sits just before the length byte
                if (i_plus1 == {1'b0, header_end_reg})
                begin
                    if (s1_byte_reg == 8'd0)
                    begin
                        chain_active_next = 1'b0;
                    end
                end
                else if (byte_count_reg == header_end_reg)
                begin
                    if (s1_byte_reg == 8'd0)
                    begin
                        chain_error_next  = 1'b1;
                        chain_active_next = 1'b0;
                    end
                    else
                    begin
                        header_end_next = ext_sum[COUNT_BITS] ? CNT_MAX
                                                              : ext_sum[COUNT_BITS-1:0];
                    end
                end
            end
            else if (byte_count_reg == header_end_reg)
            begin
                // first byte after the header carries the inner IP version
                inner_nib_next = s1_byte_reg[7:4];
            end
        end

        byte_count_next = (byte_count_reg == CNT_MAX) ? CNT_MAX
                                                      : byte_count_reg + COUNT_BITS'(1);
    end

    // Verdict from the updated state
    assign ver     = flag_byte_next[7:5];
    assign total_w = CMPW'(byte_count_next);
    assign len_v0  = CMPW'(length_field_next) + CMPW'(gtp_pkg::HDR_LEN_V0);
    assign len_v1  = CMPW'(length_field_next) + CMPW'(gtp_pkg::HDR_LEN_V1);

    always_comb
    begin
        status = gtp_pkg::ST_ACCEPTED;
        if (total_w < CMPW'(gtp_pkg::MIN_PKT_LEN))
        begin
            status = gtp_pkg::ST_SHORT;
        end
        else if (type_byte_next != gtp_pkg::TYPE_GPDU)
        begin
            status = gtp_pkg::ST_NOT_PDU;
        end
        else if ((flag_byte_next & gtp_pkg::FLAG_PT_MASK) == 8'd0)
        begin
            status = gtp_pkg::ST_GTP_PRIME;
        end
        else if (ver > 3'd1)
        begin
            status = gtp_pkg::ST_BAD_VER;
        end
        else if (ver == 3'd0)
        begin
            if (total_w < CMPW'(gtp_pkg::HDR_LEN_V0) || total_w != len_v0)
            begin
                status = gtp_pkg::ST_BAD_LENGTH;
            end
        end
        else if (chain_active_next || chain_error_next || total_w != len_v1)
        begin
            status = gtp_pkg::ST_BAD_LENGTH;
        end

        res = '0;
        res.status = status;
        if (status == gtp_pkg::ST_ACCEPTED)
        begin
            res.header_length  = gtp_pkg::HLEN_BITS'(header_end_next);
            res.multiple_encap = outer_flag_next;
            res.bypass_request = bypass_enable;
            // no inner protocol when the header fills the packet
            if (byte_count_next > header_end_next)
            begin
                if (inner_nib_next == gtp_pkg::INNER_IPV4)
                begin
                    res.next_protocol = gtp_pkg::NP_IPV4;
                end
                else if (inner_nib_next == gtp_pkg::INNER_IPV6)
                begin
                    res.next_protocol = gtp_pkg::NP_IPV6;
                end
            end
        end
    end

    // State update; clears after each verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            flag_byte_reg    <= '0;
            type_byte_reg    <= '0;
            length_field_reg <= '0;
            header_end_reg   <= '0;
            chain_active_reg <= 1'b0;
            chain_error_reg  <= 1'b0;
            inner_nib_reg    <= '0;
            outer_flag_reg   <= 1'b0;
        end
        else if (advance && s1_last_reg)
        begin
            byte_count_reg   <= '0;
            flag_byte_reg    <= '0;
            type_byte_reg    <= '0;
            length_field_reg <= '0;
            header_end_reg   <= '0;
            chain_active_reg <= 1'b0;
            chain_error_reg  <= 1'b0;
            inner_nib_reg    <= '0;
            outer_flag_reg   <= 1'b0;
        end
        else if (advance)
        begin
            byte_count_reg   <= byte_count_next;
            flag_byte_reg    <= flag_byte_next;
            type_byte_reg    <= type_byte_next;
            length_field_reg <= length_field_next;
            header_end_reg   <= header_end_next;
            chain_active_reg <= chain_active_next;
            chain_error_reg  <= chain_error_next;
            inner_nib_reg    <= inner_nib_next;
            outer_flag_reg   <= outer_flag_next;
        end
    end

endmodule

/* design/gtp_result.sv */
// Result register driving the verdict channel.
// Depends on gtp_pkg and gtp_verdict_if.
module gtp_result
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_load,
    input  gtp_pkg::verdict_t res,
    output logic              res_can_take,
    gtp_verdict_if.source     verdict
);

    logic              valid_reg;
    gtp_pkg::verdict_t data_reg;

    // Free slot, or the held item leaves this cycle
    assign res_can_take = !valid_reg || verdict.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (verdict.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            data_reg <= res;
        end
    end

    assign verdict.valid          = valid_reg;
    assign verdict.status         = data_reg.status;
    assign verdict.header_length  = data_reg.header_length;
    assign verdict.next_protocol  = data_reg.next_protocol;
    assign verdict.multiple_encap = data_reg.multiple_encap;
    assign verdict.bypass_request = data_reg.bypass_request;

endmodule
